FILE: design/olie_pkg.sv
package olie_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned DEPTH_MAX = 256;
	localparam int unsigned IDX_W     = $clog2(DEPTH_MAX);
	localparam int unsigned CMP_W     = IDX_W + 1;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned CNT_OUT_W = 5;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_TRIM      = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_ERASE     = 3'd3,
		CMD_READ_AT   = 3'd4,
		CMD_CLEAR     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [2:0]                command;
		logic [POS_W-1:0]          position;
		logic signed [WORD_W-1:0]  item_value;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [WORD_W-1:0]  read_value;
		logic [CNT_OUT_W-1:0]      element_count;
		logic signed [WORD_W-1:0]  front_value;
		logic signed [WORD_W-1:0]  back_value;
	} res_word_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
		logic              bk_en;
		logic [IDX_W-1:0]  bk_idx;
	} cell_ctl_t;

endpackage

FILE: design/ordered_list_insert_erase.sv
// Fixed-capacity ordered list of signed 32-bit words held in a row of DEPTH
// cells. Every command (append, remove last, insert, erase, read_at, clear)
// is applied to all cells in the cycle it is accepted: insert and erase shift
// the later elements by one place through the neighbor links of the cells.
// The result word (status, read value, count, front and back) is formed from
// the updated cells while the command sits in stage s1, and is then held in an
// output register. One command is taken every cycle while the result side
// does not stall (res_valid high with res_ready low); a new command can be
// accepted while the result of the previous one is still being formed.
// element_count reports the count modulo 32.
module ordered_list_insert_erase #(
	parameter int unsigned DEPTH = olie_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  olie_pkg::cmd_word_t   cmd_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output olie_pkg::res_word_t   res_word
);
	import olie_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               vld_s1;
	logic [1:0]         status_s1;
	logic               rd_s1;
	logic [IDX_W-1:0]   pos_s1;
	logic               res_valid_q;
	res_word_t          res_word_q;

	logic               cmd_fire;
	logic               s1_adv;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   pos_ext;
	logic [1:0]         status_d;
	logic               rd_d;
	cell_op_t           op_d;
	logic [IDX_W-1:0]   op_pos_d;
	cell_ctl_t          ctl;

	logic signed [WORD_W-1:0] val_w   [DEPTH];
	logic signed [WORD_W-1:0] left_w  [DEPTH];
	logic signed [WORD_W-1:0] right_w [DEPTH];
	logic signed [WORD_W-1:0] tap_rd  [DEPTH];
	logic signed [WORD_W-1:0] tap_bk  [DEPTH];
	logic signed [WORD_W-1:0] rd_or;
	logic signed [WORD_W-1:0] bk_or;
	logic signed [WORD_W-1:0] front_c;
	logic signed [WORD_W-1:0] back_c;

	assign s1_adv    = vld_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !vld_s1 || s1_adv;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cnt_ext   = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(cmd_word.position);

	always_comb begin
		status_d = ST_RANGE;
		rd_d     = 1'b0;
		op_d     = OP_HOLD;
		op_pos_d = IDX_W'(cmd_word.position);
		count_d  = count_q;
		unique case (cmd_word.command)
			CMD_APPEND: begin
				op_pos_d = IDX_W'(count_q);
				if (cnt_ext >= DEPTH_C) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					op_d     = OP_INS;
					count_d  = count_q + 1'b1;
				end
			end
			CMD_TRIM: begin
				if (count_q != '0) begin
					status_d = ST_OK;
					count_d  = count_q - 1'b1;
				end
			end
			CMD_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ST_RANGE;
				end else if (cnt_ext >= DEPTH_C) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					op_d     = OP_INS;
					count_d  = count_q + 1'b1;
				end
			end
			CMD_ERASE: begin
				if (pos_ext < cnt_ext) begin
					status_d = ST_OK;
					op_d     = OP_DEL;
					count_d  = count_q - 1'b1;
				end
			end
			CMD_READ_AT: begin
				if (pos_ext < cnt_ext) begin
					status_d = ST_OK;
					rd_d     = 1'b1;
				end
			end
			CMD_CLEAR: begin
				status_d = ST_OK;
				count_d  = '0;
			end
			default: status_d = ST_RANGE;
		endcase
	end

	always_comb begin
		ctl.op     = cmd_fire ? op_d : OP_HOLD;
		ctl.pos    = op_pos_d;
		ctl.rd_en  = rd_s1;
		ctl.rd_idx = pos_s1;
		ctl.bk_en  = (count_q != '0);
		ctl.bk_idx = IDX_W'(count_q - 1'b1);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_w[i] = cmd_word.item_value;
		end else begin : g_mid
			assign left_w[i] = val_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w[i] = val_w[i];
		end else begin : g_inner
			assign right_w[i] = val_w[i+1];
		end
		olie_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.item   (cmd_word.item_value),
			.left   (left_w[i]),
			.right  (right_w[i]),
			.value  (val_w[i]),
			.tap_rd (tap_rd[i]),
			.tap_bk (tap_bk[i])
		);
	end

	always_comb begin
		rd_or = '0;
		bk_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | tap_rd[i];
			bk_or = bk_or | tap_bk[i];
		end
	end

	assign front_c = (count_q != '0) ? val_w[0] : '0;
	assign back_c  = bk_or;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_fire) begin
				count_q <= count_d;
				vld_s1  <= 1'b1;
			end else if (s1_adv) begin
				vld_s1  <= 1'b0;
			end
			if (s1_adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			status_s1 <= status_d;
			rd_s1     <= rd_d;
			pos_s1    <= IDX_W'(cmd_word.position);
		end
		if (s1_adv) begin
			res_word_q.status        <= status_s1;
			res_word_q.read_value    <= rd_s1 ? rd_or : '0;
			res_word_q.element_count <= CNT_OUT_W'(count_q);
			res_word_q.front_value   <= front_c;
			res_word_q.back_value    <= back_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= DEPTH_C)
		else $error("element count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd_word.command == CMD_CLEAR |=> count_q == '0)
		else $error("clear left elements");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && status_s1 == ST_FULL |-> CMP_W'(count_q) == DEPTH_C)
		else $error("full status on a list that is not full");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && count_q == '0 |-> front_c == '0 && back_c == '0)
		else $error("front or back nonzero on empty list");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd_word.command != CMD_CLEAR |=>
		(count_q == $past(count_q) || count_q == CNT_W'($past(count_q) + 1'b1) ||
		 count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("count moved by more than one");
`endif

endmodule

FILE: design/olie_cell.sv
module olie_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                                 clk,
	input  olie_pkg::cell_ctl_t                  ctl,
	input  logic signed [olie_pkg::WORD_W-1:0]   item,
	input  logic signed [olie_pkg::WORD_W-1:0]   left,
	input  logic signed [olie_pkg::WORD_W-1:0]   right,
	output logic signed [olie_pkg::WORD_W-1:0]   value,
	output logic signed [olie_pkg::WORD_W-1:0]   tap_rd,
	output logic signed [olie_pkg::WORD_W-1:0]   tap_bk
);
	import olie_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [WORD_W-1:0] value_q;
	logic signed [WORD_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		case (ctl.op)
			OP_INS: begin
				if (MY_IDX == ctl.pos) begin
					value_d = item;
				end else if (MY_IDX > ctl.pos) begin
					value_d = left;
				end
			end
			OP_DEL: begin
				if (MY_IDX >= ctl.pos) begin
					value_d = right;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value  = value_q;
	assign tap_rd = (ctl.rd_en && ctl.rd_idx == MY_IDX) ? value_q : '0;
	assign tap_bk = (ctl.bk_en && ctl.bk_idx == MY_IDX) ? value_q : '0;

endmodule
